### rtl/mrq_pkg.sv
// Package for the quarter-turn matrix rotation block.
// Holds shared widths, register indexes and the controller/datapath command types.
// No dependencies.
package mrq_pkg;

  localparam int MAX_DIMENSION = 64;
  localparam int ELEMENT_WIDTH = 64;
  localparam int STORE_DEPTH   = MAX_DIMENSION * MAX_DIMENSION;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int POS_W         = ADDR_W + 1;
  localparam int DIM_W         = $clog2(MAX_DIMENSION) + 1;
  localparam int IDX_W         = $clog2(MAX_DIMENSION);
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int TURN_W        = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_TURNS = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_unavail;
    logic do_eval;
    logic do_emit;
  } mrq_cmd_t;

  typedef struct packed {
    logic op;
    logic loaded;
  } mrq_sts_t;

endpackage

### rtl/mrq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mrq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/mrq_ctrl.sv
// Controller state machine for the quarter-turn matrix rotation block.
// Depends on mrq_pkg for the command and status types.
module mrq_ctrl
  import mrq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  mrq_sts_t sts,
  output logic     busy,
  output mrq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == OP_LOAD) begin
          cmd.do_load = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!sts.loaded) begin
          cmd.do_unavail = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.do_eval = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.do_emit = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/mrq_dp.sv
// Datapath for the quarter-turn matrix rotation block: configuration registers,
// load and emit counters, source address calculation, element store and result registers.
// Depends on mrq_pkg and mrq_ram.
module mrq_dp
  import mrq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mrq_cmd_t                 cmd,
  output mrq_sts_t                 sts,
  input  logic                     in_operation,
  input  logic [ELEMENT_WIDTH-1:0] in_element_value,
  input  logic                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                     out_strobe,
  output logic [ELEMENT_WIDTH-1:0] out_result_value,
  output logic [IDX_W-1:0]         out_result_row,
  output logic [IDX_W-1:0]         out_result_column,
  output logic                     out_last_element,
  output logic                     out_unavailable
);

  logic [DIM_W-1:0]         rows_r;
  logic [DIM_W-1:0]         cols_r;
  logic [TURN_W-1:0]        turns_r;
  logic [POS_W-1:0]         load_pos_r;
  logic                     loaded_r;
  logic [IDX_W-1:0]         emit_row_r;
  logic [IDX_W-1:0]         emit_col_r;
  logic                     op_r;
  logic [ELEMENT_WIDTH-1:0] value_r;
  logic [ADDR_W-1:0]        rd_addr_r;
  logic                     strobe_r;
  logic [ELEMENT_WIDTH-1:0] res_value_r;
  logic [IDX_W-1:0]         res_row_r;
  logic [IDX_W-1:0]         res_col_r;
  logic                     res_last_r;
  logic                     res_unavail_r;

  logic [DIM_W-1:0]         cfg_dim;
  logic [2*DIM_W-1:0]       total;
  logic [POS_W-1:0]         load_base;
  logic [POS_W-1:0]         load_next;
  logic                     load_done;
  logic [DIM_W-1:0]         out_rows;
  logic [DIM_W-1:0]         out_cols;
  logic [IDX_W-1:0]         cur_i;
  logic [IDX_W-1:0]         cur_j;
  logic [DIM_W-1:0]         i_ext;
  logic [DIM_W-1:0]         j_ext;
  logic [DIM_W-1:0]         src_row;
  logic [DIM_W-1:0]         src_col;
  logic [2*DIM_W-1:0]       src_addr;
  logic                     is_last;
  logic                     col_wrap;
  logic                     row_wrap;
  logic [ELEMENT_WIDTH-1:0] ram_rdata;

  always_comb begin
    cfg_dim = cfg_data[DIM_W-1:0];
    if (cfg_dim == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (cfg_dim > DIM_W'(MAX_DIMENSION)) begin
      cfg_dim = DIM_W'(MAX_DIMENSION);
    end
  end

  assign total     = rows_r * cols_r;
  assign load_base = (loaded_r || ((2*DIM_W)'(load_pos_r) >= total)) ? '0 : load_pos_r;
  assign load_next = load_base + POS_W'(1);
  assign load_done = ((2*DIM_W)'(load_next) >= total);

  always_comb begin
    out_rows = turns_r[0] ? cols_r : rows_r;
    out_cols = turns_r[0] ? rows_r : cols_r;
    if ((DIM_W'(emit_row_r) >= out_rows) || (DIM_W'(emit_col_r) >= out_cols)) begin
      cur_i = '0;
      cur_j = '0;
    end else begin
      cur_i = emit_row_r;
      cur_j = emit_col_r;
    end
    i_ext = DIM_W'(cur_i);
    j_ext = DIM_W'(cur_j);
    case (turns_r)
      2'd1: begin
        src_row = j_ext;
        src_col = cols_r - DIM_W'(1) - i_ext;
      end
      2'd2: begin
        src_row = rows_r - DIM_W'(1) - i_ext;
        src_col = cols_r - DIM_W'(1) - j_ext;
      end
      2'd3: begin
        src_row = rows_r - DIM_W'(1) - j_ext;
        src_col = i_ext;
      end
      default: begin
        src_row = i_ext;
        src_col = j_ext;
      end
    endcase
    src_addr = src_row * cols_r + (2*DIM_W)'(src_col);
    col_wrap = (j_ext == out_cols - DIM_W'(1));
    row_wrap = (i_ext == out_rows - DIM_W'(1));
    is_last  = col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= DIM_W'(1);
      cols_r     <= DIM_W'(1);
      turns_r    <= '0;
      load_pos_r <= '0;
      loaded_r   <= 1'b0;
      emit_row_r <= '0;
      emit_col_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_COUNT: begin
            rows_r     <= cfg_dim;
            loaded_r   <= 1'b0;
            load_pos_r <= '0;
            emit_row_r <= '0;
            emit_col_r <= '0;
          end
          REG_COLUMN_COUNT: begin
            cols_r     <= cfg_dim;
            loaded_r   <= 1'b0;
            load_pos_r <= '0;
            emit_row_r <= '0;
            emit_col_r <= '0;
          end
          REG_QUARTER_TURNS: begin
            turns_r    <= cfg_data[TURN_W-1:0];
            emit_row_r <= '0;
            emit_col_r <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.do_load) begin
        emit_row_r <= '0;
        emit_col_r <= '0;
        if (load_done) begin
          loaded_r   <= 1'b1;
          load_pos_r <= '0;
        end else begin
          loaded_r   <= 1'b0;
          load_pos_r <= load_next;
        end
      end
      if (cmd.do_unavail) begin
        strobe_r <= 1'b1;
      end
      if (cmd.do_eval) begin
        if (!col_wrap) begin
          emit_row_r <= cur_i;
          emit_col_r <= cur_j + IDX_W'(1);
        end else begin
          emit_col_r <= '0;
          emit_row_r <= row_wrap ? '0 : cur_i + IDX_W'(1);
        end
      end
      if (cmd.do_emit) begin
        strobe_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      value_r <= in_element_value;
    end
    if (cmd.do_unavail) begin
      res_value_r   <= '0;
      res_row_r     <= '0;
      res_col_r     <= '0;
      res_last_r    <= 1'b0;
      res_unavail_r <= 1'b1;
    end
    if (cmd.do_eval) begin
      rd_addr_r     <= src_addr[ADDR_W-1:0];
      res_row_r     <= cur_i;
      res_col_r     <= cur_j;
      res_last_r    <= is_last;
      res_unavail_r <= 1'b0;
    end
    if (cmd.do_emit) begin
      res_value_r <= ram_rdata;
    end
  end

  mrq_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.do_load),
    .waddr (load_base[ADDR_W-1:0]),
    .wdata (value_r),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign sts.op            = op_r;
  assign sts.loaded        = loaded_r;
  assign out_strobe        = strobe_r;
  assign out_result_value  = res_value_r;
  assign out_result_row    = res_row_r;
  assign out_result_column = res_col_r;
  assign out_last_element  = res_last_r;
  assign out_unavailable   = res_unavail_r;

endmodule

### rtl/matrix_rotate_quarter_turns.sv
// Top level of the quarter-turn matrix rotation block.
// Depends on mrq_pkg, mrq_ctrl and mrq_dp.
//
//   Channel  Handshake             Payload
//   in_      start / busy          in_operation, in_element_value
//   out_     out_strobe            out_result_value, _row, _column, out_last_element,
//                                  out_unavailable
//   cfg_     cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load keeps busy high while the controller is in its execute state. A read
// without a loaded matrix gives its result from the execute state, a read of a
// loaded matrix through the read and emit states, set by the registered read of the
// element store; the next transfer can be taken at the edge that ends the result.
// Reset is synchronous and active low; it drops any matrix and sets 1x1, no turns.
// Results cannot be stalled: out_strobe is high for exactly one cycle.
module matrix_rotate_quarter_turns
  import mrq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_operation,
  input  logic [ELEMENT_WIDTH-1:0] in_element_value,
  output logic                     out_strobe,
  output logic [ELEMENT_WIDTH-1:0] out_result_value,
  output logic [IDX_W-1:0]         out_result_row,
  output logic [IDX_W-1:0]         out_result_column,
  output logic                     out_last_element,
  output logic                     out_unavailable,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  mrq_cmd_t cmd;
  mrq_sts_t sts;

  assign cfg_ready = !busy;

  mrq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  mrq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_element_value  (in_element_value),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_strobe        (out_strobe),
    .out_result_value  (out_result_value),
    .out_result_row    (out_result_row),
    .out_result_column (out_result_column),
    .out_last_element  (out_last_element),
    .out_unavailable   (out_unavailable)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_LOAD)) |-> ##1 !out_strobe ##1 !out_strobe)
    else $error("load transfer produced a result");

  a_unavail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_unavailable) |->
      (out_result_row == '0) && (out_result_column == '0) && !out_last_element)
    else $error("unavailable result carries coordinates");

endmodule
